>>> src/hkrb_pkg.sv
// Shared types, constants and character-to-usage mapping for the keyboard report builder.
package hkrb_pkg;

  typedef enum logic [1:0] {
    FUNC_PRESS       = 2'd0,
    FUNC_RELEASE     = 2'd1,
    FUNC_RELEASE_ALL = 2'd2
  } func_e;

  localparam int unsigned OutSlots = 6;

  localparam logic [7:0] MOD_NONE   = 8'h00;
  localparam logic [7:0] MOD_LSHIFT = 8'h02;

  localparam logic [7:0] USAGE_NONE  = 8'd0;
  localparam logic [7:0] USAGE_A     = 8'd4;
  localparam logic [7:0] USAGE_1     = 8'd30;
  localparam logic [7:0] USAGE_0     = 8'd39;
  localparam logic [7:0] USAGE_ENTER = 8'd40;
  localparam logic [7:0] USAGE_SPACE = 8'd44;

  localparam logic [7:0] CHAR_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LZ    = 8'h7A;  // 'z'
  localparam logic [7:0] CHAR_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UZ    = 8'h5A;  // 'Z'
  localparam logic [7:0] CHAR_ONE   = 8'h31;  // '1'
  localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  typedef struct packed {
    logic [7:0] usage;
    logic [7:0] modifier;
  } key_map_t;

  function automatic key_map_t map_char(input logic [7:0] c);
    key_map_t m;
    m.usage    = USAGE_NONE;
    m.modifier = MOD_NONE;
    if (c >= CHAR_LA && c <= CHAR_LZ) begin
      m.usage = USAGE_A + (c - CHAR_LA);
    end else if (c >= CHAR_UA && c <= CHAR_UZ) begin
      m.usage    = USAGE_A + (c - CHAR_UA);
      m.modifier = MOD_LSHIFT;
    end else if (c >= CHAR_ONE && c <= CHAR_NINE) begin
      m.usage = USAGE_1 + (c - CHAR_ONE);
    end else if (c == CHAR_ZERO) begin
      m.usage = USAGE_0;
    end else if (c == CHAR_SPACE) begin
      m.usage = USAGE_SPACE;
    end else if (c == CHAR_LF || c == CHAR_CR) begin
      m.usage = USAGE_ENTER;
    end
    return m;
  endfunction

endpackage

>>> src/hid_keyboard_report_builder_core.sv
// Boot keyboard report builder: key events in, 8-byte six-key rollover reports out.
//
// Input stream: one key event per beat. tuser carries the function code
// (press, release, release all); tdata carries the ASCII character and the
// link-up flag. Output stream: one 8-byte report per beat, byte 0 in the
// lowest bits. A report is sent only for a mapped press or release, or a
// release all, while enabled and with link_up set; unmapped characters on
// press or release and the unused function code change nothing and send nothing.
// A beat is captured in the input register; the key slot update and report
// are formed from it and land in the output register.
// Throughput: one event per cycle while the receiver does not stall; the slot
// compare and first-free pick fit in the single stage between the two registers.
// Reset clears the enable, the held modifier, all key slots and the valid
// flags of both pipeline registers. When the receiver stalls, the report
// holds in the output register, the input register holds the next event,
// and tready drops only once both are full.
module hid_keyboard_report_builder_core
  import hkrb_pkg::*;
#(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,     // enabled
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [7:0] key_char, [8] link_up, [15:9] zero
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o   // modifier_byte, reserved_byte, key_code_0..5
);

  logic       enabled_q;
  logic       in_valid_q;
  func_e      func_q;
  logic [7:0] char_q;
  logic       link_q;
  logic       out_valid_q, out_valid_d;
  logic [7:0] mod_q, mod_d;
  logic [7:0] slots_q [KEY_SLOTS];
  logic [7:0] slots_d [KEY_SLOTS];
  logic [63:0] report_q, report_d;
  logic       advance;
  logic       emit;
  key_map_t   mapped;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign mapped          = map_char(char_q);

  always_comb begin
    logic hit;
    logic placed;
    logic cleared;
    hit     = 1'b0;
    placed  = 1'b0;
    cleared = 1'b0;
    emit    = 1'b0;
    mod_d   = mod_q;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      slots_d[i] = slots_q[i];
    end
    if (in_valid_q && advance) begin
      unique case (func_q)
        FUNC_PRESS: begin
          if (mapped.usage != USAGE_NONE) begin
            emit  = 1'b1;
            mod_d = mapped.modifier;
            for (int i = 0; i < KEY_SLOTS; i++) begin
              if (slots_q[i] == mapped.usage) hit = 1'b1;
            end
            for (int i = 0; i < KEY_SLOTS; i++) begin
              if (!hit && !placed && slots_q[i] == USAGE_NONE) begin
                slots_d[i] = mapped.usage;
                placed     = 1'b1;
              end
            end
          end
        end
        FUNC_RELEASE: begin
          if (mapped.usage != USAGE_NONE) begin
            emit  = 1'b1;
            mod_d = MOD_NONE;
            for (int i = 0; i < KEY_SLOTS; i++) begin
              if (!cleared && slots_q[i] == mapped.usage) begin
                slots_d[i] = USAGE_NONE;
                cleared    = 1'b1;
              end
            end
          end
        end
        FUNC_RELEASE_ALL: begin
          emit  = 1'b1;
          mod_d = MOD_NONE;
          for (int i = 0; i < KEY_SLOTS; i++) begin
            slots_d[i] = USAGE_NONE;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
      emit = emit && enabled_q && link_q;
    end
  end

  assign report_d[7:0]  = mod_d;
  assign report_d[15:8] = 8'h00;
  for (genvar j = 0; j < OutSlots; j++) begin : g_report
    if (j < KEY_SLOTS) begin : g_used
      assign report_d[16 + 8*j +: 8] = slots_d[j];
    end else begin : g_unused
      assign report_d[16 + 8*j +: 8] = USAGE_NONE;
    end
  end

  always_comb begin
    if (advance) begin
      out_valid_d = emit;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mod_q       <= MOD_NONE;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        slots_q[i] <= USAGE_NONE;
      end
    end else begin
      if (cfg_we_i) begin
        enabled_q <= cfg_wdata_i;
      end
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      out_valid_q <= out_valid_d;
      mod_q       <= mod_d;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        slots_q[i] <= slots_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      func_q <= func_e'(s_axis_tuser_i);
      char_q <= s_axis_tdata_i[7:0];
      link_q <= s_axis_tdata_i[8];
    end
    if (advance && emit) begin
      report_q <= report_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = report_q;

endmodule

>>> test/hid_keyboard_report_builder_core_tb.sv
// Testbench for the keyboard report builder: predicts each report and checks it.
module hid_keyboard_report_builder_core_tb;
  import hkrb_pkg::*;

  localparam logic [1:0] FuncUnused = 2'd3;

  class report_scoreboard;
    bit         enabled;
    logic [7:0] held_mod;
    logic [7:0] slots[OutSlots];
    logic [63:0] pending_reports[$];
    int errors;
    int events_taken;
    int reports_seen;
    string field_names[8] = '{"modifier_byte", "reserved_byte", "key_code_0", "key_code_1",
                              "key_code_2", "key_code_3", "key_code_4", "key_code_5"};

    function new();
      enabled  = 1'b0;
      held_mod = MOD_NONE;
      foreach (slots[i]) slots[i] = USAGE_NONE;
    endfunction

    function void mismatch(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endfunction

    function logic [7:0] usage_of(logic [7:0] c, output logic [7:0] mod);
      mod = MOD_NONE;
      if (c >= CHAR_LA && c <= CHAR_LZ) return USAGE_A + (c - CHAR_LA);
      if (c >= CHAR_UA && c <= CHAR_UZ) begin
        mod = MOD_LSHIFT;
        return USAGE_A + (c - CHAR_UA);
      end
      if (c >= CHAR_ONE && c <= CHAR_NINE) return USAGE_1 + (c - CHAR_ONE);
      case (c)
        CHAR_ZERO:      return USAGE_0;
        CHAR_SPACE:     return USAGE_SPACE;
        CHAR_LF, CHAR_CR: return USAGE_ENTER;
        default:        return USAGE_NONE;
      endcase
    endfunction

    function void set_enable(bit en);
      enabled = en;
    endfunction

    // Called on every accepted input beat.
    function void note_event(logic [1:0] f, logic [7:0] c, logic link);
      logic [7:0]  usage;
      logic [7:0]  mod;
      bit          done;
      logic [63:0] rpt;
      if (f == FUNC_PRESS || f == FUNC_RELEASE) begin
        usage = usage_of(c, mod);
        if (usage == USAGE_NONE) return;
        done = 1'b0;
        if (f == FUNC_PRESS) begin
          held_mod = mod;
          foreach (slots[i]) if (slots[i] == usage) done = 1'b1;
          foreach (slots[i]) begin
            if (!done && slots[i] == USAGE_NONE) begin
              slots[i] = usage;
              done = 1'b1;
            end
          end
        end else begin
          held_mod = MOD_NONE;
          foreach (slots[i]) begin
            if (!done && slots[i] == usage) begin
              slots[i] = USAGE_NONE;
              done = 1'b1;
            end
          end
        end
      end else if (f == FUNC_RELEASE_ALL) begin
        held_mod = MOD_NONE;
        foreach (slots[i]) slots[i] = USAGE_NONE;
      end else begin
        return;
      end
      events_taken++;
      if (enabled && link) begin
        rpt = '0;
        rpt[7:0] = held_mod;
        foreach (slots[i]) rpt[16 + 8 * i +: 8] = slots[i];
        pending_reports.push_back(rpt);
      end
    endfunction

    function void check_report(logic [63:0] got);
      logic [63:0] want;
      reports_seen++;
      if (pending_reports.size() == 0) begin
        mismatch($sformatf("unexpected report %h", got));
        return;
      end
      want = pending_reports.pop_front();
      for (int b = 0; b < 8; b++) begin
        if (got[8 * b +: 8] !== want[8 * b +: 8])
          mismatch($sformatf("report %0d %s: got %h want %h", reports_seen, field_names[b],
                             got[8 * b +: 8], want[8 * b +: 8]));
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;   // [7:0] key_char, [8] link_up, [15:9] zero
  logic [1:0]  s_axis_tuser_i;   // [1:0] func
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;   // modifier_byte, reserved_byte, key_code_0..5

  report_scoreboard sb;
  int send_idle_pct;
  int stall_pct;

  hid_keyboard_report_builder_core i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_report(m_axis_tdata_o);
  end

  // Enters and leaves at a falling edge.
  task automatic send_event(logic [1:0] f, logic [7:0] c, logic link);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'b0, link, c};
    s_axis_tuser_i  <= f;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_event(f, c, link);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_enable(bit en);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= en;
    @(posedge clk_i);
    sb.set_enable(en);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 35) return CHAR_LA + 8'($urandom_range(25));
    if (r < 55) return CHAR_UA + 8'($urandom_range(25));
    if (r < 70) return CHAR_ONE + 8'($urandom_range(8));
    if (r < 75) return CHAR_ZERO;
    if (r < 80) return CHAR_SPACE;
    if (r < 85) return $urandom_range(1) ? CHAR_LF : CHAR_CR;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic pick_link();
    return $urandom_range(99) < 85;
  endfunction

  // Mostly chords: a few keys pressed, then released (some left stuck).
  task automatic run_random(int n_events);
    int          start;
    int          r;
    int          k;
    logic [7:0]  keys[8];
    start = sb.events_taken;
    while (sb.events_taken - start < n_events) begin
      r = $urandom_range(99);
      if (r < 80) begin
        k = $urandom_range(1, 8);
        for (int i = 0; i < k; i++) begin
          keys[i] = pick_char();
          send_event(FUNC_PRESS, keys[i], pick_link());
        end
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(99) >= 15)
            send_event(FUNC_RELEASE, $urandom_range(1) ? keys[i] : keys[k - 1 - i], pick_link());
        end
      end else if (r < 88) begin
        send_event(FUNC_RELEASE_ALL, 8'($urandom_range(255)), pick_link());
      end else if (r < 92) begin
        send_event(FuncUnused, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        send_event(2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    sb = new();
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_enable(1'b1);

    // directed: range edges, full slots, duplicates, unmapped, unused code
    send_event(FUNC_PRESS, CHAR_LA, 1'b1);
    send_event(FUNC_PRESS, CHAR_LZ, 1'b1);
    send_event(FUNC_PRESS, CHAR_UA, 1'b1);
    send_event(FUNC_PRESS, CHAR_UZ, 1'b1);
    send_event(FUNC_PRESS, CHAR_ONE, 1'b1);
    send_event(FUNC_PRESS, CHAR_NINE, 1'b1);
    send_event(FUNC_PRESS, CHAR_ZERO, 1'b1);
    send_event(FUNC_PRESS, CHAR_SPACE, 1'b1);
    send_event(FUNC_PRESS, CHAR_LF, 1'b1);
    send_event(FUNC_RELEASE, CHAR_LZ, 1'b0);
    send_event(FUNC_PRESS, CHAR_CR, 1'b1);
    send_event(FUNC_RELEASE, 8'h71, 1'b1);
    send_event(FUNC_PRESS, 8'h00, 1'b1);
    send_event(FUNC_PRESS, 8'hFF, 1'b1);
    send_event(FUNC_RELEASE, 8'h7B, 1'b1);
    send_event(FuncUnused, CHAR_LA, 1'b1);
    send_event(FUNC_RELEASE_ALL, 8'hFF, 1'b1);
    send_event(FUNC_PRESS, 8'h40, 1'b1);
    send_event(FUNC_PRESS, 8'h5B, 1'b1);
    send_event(FUNC_PRESS, 8'h60, 1'b1);
    send_event(FUNC_PRESS, 8'h7B, 1'b1);
    send_event(FUNC_PRESS, 8'h2F, 1'b1);
    send_event(FUNC_PRESS, 8'h3A, 1'b1);
    send_event(FUNC_RELEASE_ALL, 8'h00, 1'b0);
    send_event(FUNC_PRESS, CHAR_UA + 8'd12, 1'b1);

    // disabled: state still moves, nothing is reported
    write_enable(1'b0);
    send_idle_pct = 37;
    stall_pct     = 37;
    run_random(40);
    write_enable(1'b1);

    send_idle_pct = 0;
    stall_pct     = 0;
    run_random(210);
    wait_idle();
    send_idle_pct = 45;
    run_random(210);
    wait_idle();
    send_idle_pct = 0;
    stall_pct     = 45;
    run_random(210);
    wait_idle();
    send_idle_pct = 37;
    stall_pct     = 37;
    run_random(210);

    wait_idle();
    if (sb.pending_reports.size() != 0) sb.mismatch("reports still pending at end");
    $display("Run covered %0d key events and %0d reports, %0d mismatches,",
             sb.events_taken, sb.reports_seen, sb.errors);
    $display("  with enable toggled and sender gaps and receiver stalls mixed.");
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> hid_keyboard_report_builder_core.f
src/hkrb_pkg.sv
src/hid_keyboard_report_builder_core.sv
test/hid_keyboard_report_builder_core_tb.sv
